/* sv/assert_macros.svh */
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, off while reset is held.
`define ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* sv/lncc_pkg.sv */
// Package: sizes, codes, control types and key folding for the name cache.
`timescale 1ns / 1ps

package lncc_pkg;

    localparam int MAX_ENTRIES = 32;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int CFG_W       = 6;
    localparam int CAP_W       = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int WORD_W      = 64;
    localparam int KEY_W       = 3 * WORD_W;
    localparam int COST_W      = 3;
    localparam int TOTAL_W     = 32;

    localparam logic [COST_W-1:0] COST_HIT  = 3'd1;
    localparam logic [COST_W-1:0] COST_MISS = 3'd5;

    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [7:0] ASCII_CASE_OFS = 8'h20;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } t_state;

    typedef struct packed {
        logic load_key;
        logic lookup;
        logic update;
    } t_dp_cmd;

    typedef struct packed {
        logic out_stall;
    } t_dp_status;

    // Fold A-Z to lower case, byte by byte; every other byte passes as is.
    function automatic logic [WORD_W-1:0] fold_word(input logic [WORD_W-1:0] w);
        logic [7:0]        b;
        logic [WORD_W-1:0] r;
        r = '0;
        for (int i = 0; i < WORD_W / 8; i++) begin
            b = w[8*i +: 8];
            if (b >= ASCII_UPPER_A && b <= ASCII_UPPER_Z) begin
                b = b + ASCII_CASE_OFS;
            end
            r[8*i +: 8] = b;
        end
        return r;
    endfunction

endpackage

/* sv/lncc_in_if.sv */
// Interfaces: request channel (name words) and response channel (hit and cost).
`timescale 1ns / 1ps

interface lncc_in_if import lncc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] name_bytes_0_7;
    logic [WORD_W-1:0] name_bytes_8_15;
    logic [WORD_W-1:0] name_bytes_16_23;

    modport source (output valid, output name_bytes_0_7, output name_bytes_8_15,
                    output name_bytes_16_23, input ready);
    modport sink   (input valid, input name_bytes_0_7, input name_bytes_8_15,
                    input name_bytes_16_23, output ready);
endinterface

interface lncc_out_if import lncc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               hit;
    logic [COST_W-1:0]  access_cost;
    logic [TOTAL_W-1:0] total_cost;

    modport source (output valid, output hit, output access_cost, output total_cost,
                    input ready);
    modport sink   (input valid, input hit, input access_cost, input total_cost,
                    output ready);
endinterface

/* sv/lncc_ctrl.sv */
// Controller: sequences accept, lookup and recency update of one word at a time.
`timescale 1ns / 1ps

module lncc_ctrl import lncc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    // Take a word when idle, or in the update cycle when the result can leave
    always_comb begin
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: o_in_ready = 1'b1;
            ST_UPD:  o_in_ready = !i_status.out_stall;
            default: o_in_ready = 1'b0;
        endcase
    end

    assign w_accept = i_in_valid && o_in_ready;

    // Drive datapath commands
    always_comb begin
        o_cmd          = '0;
        o_cmd.load_key = w_accept;
        case (r_state)
            ST_CMP:  o_cmd.lookup = 1'b1;
            ST_UPD:  o_cmd.update = !i_status.out_stall;
            default: o_cmd.lookup = 1'b0;
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP: n_state = ST_UPD;
            ST_UPD: begin
                if (!i_status.out_stall) begin
                    n_state = w_accept ? ST_CMP : ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* sv/lncc_dp.sv */
// Datapath: entry store, parallel key compare, recency ranks, cost total, result register.
`timescale 1ns / 1ps

module lncc_dp import lncc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic [WORD_W-1:0]  i_name_lo,
    input  logic [WORD_W-1:0]  i_name_mid,
    input  logic [WORD_W-1:0]  i_name_hi,
    input  t_dp_cmd            i_cmd,
    output t_dp_status         o_status,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic               o_out_hit,
    output logic [COST_W-1:0]  o_out_cost,
    output logic [TOTAL_W-1:0] o_out_total
);

    logic [CFG_W-1:0]       r_cache_size;
    logic [KEY_W-1:0]       r_key;
    logic [KEY_W-1:0]       r_entry_key [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] r_valid;
    logic [MAX_ENTRIES-1:0] n_valid;
    logic [IDX_W-1:0]       r_rank [MAX_ENTRIES];
    logic [IDX_W-1:0]       n_rank [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] r_hit_vec;
    logic [MAX_ENTRIES-1:0] w_match;
    logic                   r_hit;
    logic [CAP_W-1:0]       w_cap;
    logic [CAP_W-1:0]       w_cap_lim;
    logic                   w_cap_zero;
    logic [IDX_W-1:0]       w_hit_rank;
    logic [MAX_ENTRIES-1:0] w_free;
    logic [MAX_ENTRIES-1:0] w_ins_oh;
    logic                   w_hit;
    logic                   w_key_we;
    logic [COST_W-1:0]      w_cost;
    logic [TOTAL_W:0]       w_sum;
    logic [TOTAL_W-1:0]     w_total;
    logic                   r_out_valid;
    logic                   r_out_hit;
    logic [COST_W-1:0]      r_out_cost;
    logic [TOTAL_W-1:0]     r_total;

    // Hold the size register; clamp to the store depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cache_size <= '0;
        end else if (i_cfg_we) begin
            r_cache_size <= i_cfg_data;
        end
    end

    assign w_cap      = (CAP_W'(r_cache_size) > CAP_W'(MAX_ENTRIES))
                        ? CAP_W'(MAX_ENTRIES) : CAP_W'(r_cache_size);
    assign w_cap_zero = (w_cap == '0);
    assign w_cap_lim  = w_cap - CAP_W'(1);

    // Latch the folded key on accept
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_key) begin
            r_key <= {fold_word(i_name_hi), fold_word(i_name_mid), fold_word(i_name_lo)};
        end
    end

    // Compare the key against every valid entry at once
    always_comb begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            w_match[i] = r_valid[i] && (r_entry_key[i] == r_key);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_hit_vec <= w_match;
            r_hit     <= |w_match;
        end
    end

    // Rank of the hit entry; free slots after eviction; lowest free slot
    always_comb begin
        w_hit_rank = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (r_hit_vec[i]) begin
                w_hit_rank = w_hit_rank | r_rank[i];
            end
            w_free[i] = !r_valid[i] || (CAP_W'(r_rank[i]) >= w_cap_lim);
        end
        w_ins_oh = w_free & (~w_free + MAX_ENTRIES'(1));
    end

    assign w_hit    = r_hit && !w_cap_zero;
    assign w_key_we = i_cmd.update && !w_cap_zero && !r_hit;

    // Reorder recency: promote on hit, age and evict then insert on miss
    always_comb begin
        n_valid = r_valid;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            n_rank[i] = r_rank[i];
        end
        if (i_cmd.update && !w_cap_zero) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (r_hit) begin
                    if (r_hit_vec[i]) begin
                        n_rank[i] = '0;
                    end else if (r_valid[i] && (r_rank[i] < w_hit_rank)) begin
                        n_rank[i] = r_rank[i] + IDX_W'(1);
                    end
                end else begin
                    if (r_valid[i]) begin
                        if (CAP_W'(r_rank[i]) >= w_cap_lim) begin
                            n_valid[i] = 1'b0;
                        end else begin
                            n_rank[i] = r_rank[i] + IDX_W'(1);
                        end
                    end
                    if (w_ins_oh[i]) begin
                        n_valid[i] = 1'b1;
                        n_rank[i]  = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            r_valid <= n_valid;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                r_rank[i] <= n_rank[i];
            end
        end
    end

    // Store the key into the chosen slot on a miss
    always_ff @(posedge i_clk) begin
        if (w_key_we) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (w_ins_oh[i]) begin
                    r_entry_key[i] <= r_key;
                end
            end
        end
    end

    // Saturating cost total
    assign w_cost  = w_hit ? COST_HIT : COST_MISS;
    assign w_sum   = {1'b0, r_total} + (TOTAL_W + 1)'(w_cost);
    assign w_total = w_sum[TOTAL_W] ? '1 : w_sum[TOTAL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else if (i_cmd.update) begin
            r_total     <= w_total;
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Load the result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_out_hit  <= w_hit;
            r_out_cost <= w_cost;
        end
    end

    assign o_status.out_stall = r_out_valid && !i_out_ready;
    assign o_out_valid        = r_out_valid;
    assign o_out_hit          = r_out_hit;
    assign o_out_cost         = r_out_cost;
    assign o_out_total        = r_total;

endmodule

/* sv/lru_name_cache_cost_unit.sv */
// Top level: fully associative LRU cache of 24-byte names with a saturating cost total.
// Each word passes through the compare and update states: after acceptance the folded
// name is compared with all 32 entries in parallel in the compare state, and the recency
// ranks, cost total and result register are updated in the update state; the next word is
// taken in that update cycle when the result register is free, so a new word is accepted
// in the same cycle as the update of the last one. The result register holds until taken;
// while it stalls, the update waits. The store needs no clearing after reset. Write
// cache_size only while the block is idle.
`timescale 1ns / 1ps

module lru_name_cache_cost_unit import lncc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data,
    lncc_in_if.sink          i_req,
    lncc_out_if.source       o_rsp
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic       w_in_ready;

    assign i_req.ready = w_in_ready;

    lncc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_status   (w_status),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    lncc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_name_lo   (i_req.name_bytes_0_7),
        .i_name_mid  (i_req.name_bytes_8_15),
        .i_name_hi   (i_req.name_bytes_16_23),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (o_rsp.valid),
        .o_out_hit   (o_rsp.hit),
        .o_out_cost  (o_rsp.access_cost),
        .o_out_total (o_rsp.total_cost)
    );

endmodule

/* sv/lncc_chk.sv */
// Checker on the top-level ports of the name cache, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lncc_chk import lncc_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_cfg_we,
    input logic [CFG_W-1:0]   i_cfg_data,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic               i_out_hit,
    input logic [COST_W-1:0]  i_out_cost,
    input logic [TOTAL_W-1:0] i_out_total
);

    logic               r_size_zero;
    logic [TOTAL_W-1:0] r_prev_total;
    logic [TOTAL_W:0]   w_sum;
    logic [TOTAL_W-1:0] w_expect;
    logic               w_out_acc;

    assign w_out_acc = i_out_valid && i_out_ready;

    // Track whether caching is off
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_zero <= 1'b1;
        end else if (i_cfg_we) begin
            r_size_zero <= (i_cfg_data == '0);
        end
    end

    // Track the last delivered total
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_total <= '0;
        end else if (w_out_acc) begin
            r_prev_total <= i_out_total;
        end
    end

    assign w_sum    = {1'b0, r_prev_total} + (TOTAL_W + 1)'(i_out_cost);
    assign w_expect = w_sum[TOTAL_W] ? '1 : w_sum[TOTAL_W-1:0];

    `ASSERT_NXT(a_rsp_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_hit) && $stable(i_out_cost) && $stable(i_out_total))
    `ASSERT_NXT(a_busy_after_accept, i_in_valid && i_in_ready, !i_in_ready)
    `ASSERT_IMP(a_total_step, w_out_acc, i_out_total == w_expect)
    `ASSERT_IMP(a_off_never_hits, i_out_valid && r_size_zero, !i_out_hit && i_out_cost == COST_MISS)

endmodule

bind lru_name_cache_cost_unit lncc_chk u_lncc_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_data  (i_cfg_data),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out_hit   (o_rsp.hit),
    .i_out_cost  (o_rsp.access_cost),
    .i_out_total (o_rsp.total_cost)
);
